>>> design/ppsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppsc_pkg;

    localparam int MAX_VERTS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int Q14_ONE         = 16384;
    localparam int Q14_BITS        = 14;
    localparam int QUOT_BITS       = 15;

    localparam logic signed [31:0] DEPTH_MAX = 32'sh7fffffff;

    typedef enum logic [2:0] {
        CMD_VERT_A   = 3'd0,
        CMD_VERT_B   = 3'd1,
        CMD_CENTRE_A = 3'd2,
        CMD_CENTRE_B = 3'd3,
        CMD_COMPUTE  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVF   = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        UOP_SQRT = 1'b0,
        UOP_DIV  = 1'b1
    } t_uop;

    typedef struct packed {
        logic start;
        t_uop op;
    } t_unit_req;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] depth;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic [1:0]         status;
    } t_out_word;

endpackage

`default_nettype wire

>>> design/ppsc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppsc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/ppsc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module ppsc_mul
    import ppsc_pkg::*;
#(
    parameter int VW = COORD_WIDTH_DEF + 1
) (
    input  wire logic                  i_clk,
    input  wire logic signed [VW-1:0]  i_a,
    input  wire logic signed [VW-1:0]  i_b,
    output logic signed [2*VW-1:0]     o_p
);

    logic signed [2*VW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

>>> design/ppsc_rootdiv.sv
`timescale 1ns / 1ps
`default_nettype none

module ppsc_rootdiv
    import ppsc_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_unit_req         i_req,
    input  wire logic [2*CW+1:0]   i_rad,
    input  wire logic [CW+15:0]    i_num,
    input  wire logic [CW:0]       i_den,
    output logic                   o_done,
    output logic [CW:0]            o_res
);

    localparam int SW  = 2 * CW + 2;
    localparam int UW  = CW + 16;
    localparam int LW  = CW + 1;
    localparam int CNW = $clog2(CW + 2);

    logic           r_busy;
    logic           r_done;
    t_uop           r_op;
    logic [CNW-1:0] r_cnt;
    logic [SW-1:0]  r_rad;
    logic [UW-1:0]  r_rem;
    logic [UW-1:0]  r_div;
    logic [LW-1:0]  r_root;

    logic [UW-1:0]  opa;
    logic [UW-1:0]  opb;
    logic [UW-1:0]  diff;
    logic           ge;

    // one compare and subtract per cycle, radicand pairs or shifted divisor
    always_comb begin
        if (r_op == UOP_SQRT) begin
            opa = {r_rem[UW-3:0], r_rad[SW-1 -: 2]};
            opb = UW'({r_root, 2'b01});
        end else begin
            opa = r_rem;
            opb = r_div;
        end
        ge   = (opa >= opb);
        diff = opa - opb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= UOP_SQRT;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= (i_req.op == UOP_SQRT) ? CNW'(CW) : CNW'(QUOT_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_rad;
            r_rem  <= (i_req.op == UOP_SQRT) ? '0 : i_num;
            r_div  <= UW'(i_den) << Q14_BITS;
            r_root <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff : opa;
            r_root <= {r_root[LW-2:0], ge};
            r_rad  <= r_rad << 2;
            r_div  <= r_div >> 1;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_root;

endmodule

`default_nettype wire

>>> design/polygon_pair_sat_contact.sv
// Separating-axis contact between two convex polygons.
// Input channel i_in carries one word per handshake: cmd 0 and 1 append a
// vertex to polygon A or B, cmd 2 and 3 set the centre of A or B, cmd 4
// starts the contact search. Loads are taken one per cycle while idle.
// A compute word yields one result word on o_out; all other words yield none.
// Compute walks every edge of A then every edge of B. A usable edge takes a
// square root and two divides in the shared iterative unit (one bit a
// cycle), a projection of every vertex of the other polygon and a contact
// search, with each product in the single shared multiplier, used once per
// product; a degenerate edge is skipped.
// An empty polygon goes from the compute word straight to the result.
// i_in.ready is low for the whole compute. The result sits in an output
// register: new loads are accepted while it waits, and a following compute
// holds at its end until the receiver has taken the earlier result.
// Reset (synchronous, active low) empties both vertex stores, zeroes the
// centres and the overflow flag and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module polygon_pair_sat_contact
    import ppsc_pkg::*;
#(
    parameter int MAX_VERTS   = MAX_VERTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ppsc_if.sink        i_in,
    ppsc_if.source      o_out
);

    localparam int CW   = COORD_WIDTH;
    localparam int VW   = CW + 1;
    localparam int PW   = 2 * VW;
    localparam int DW   = CW + 17;
    localparam int LW   = CW + 1;
    localparam int UW   = CW + 16;
    localparam int AW   = $clog2(MAX_VERTS);
    localparam int CNTW = $clog2(MAX_VERTS + 1);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_pt;

    typedef enum logic [22:0] {
        S_IDLE = 23'd1 << 0,
        S_RI   = 23'd1 << 1,
        S_RJ   = 23'd1 << 2,
        S_DL   = 23'd1 << 3,
        S_SQX  = 23'd1 << 4,
        S_SQY  = 23'd1 << 5,
        S_SQS  = 23'd1 << 6,
        S_RT   = 23'd1 << 7,
        S_DXS  = 23'd1 << 8,
        S_DVX  = 23'd1 << 9,
        S_DYS  = 23'd1 << 10,
        S_DVY  = 23'd1 << 11,
        S_OWNX = 23'd1 << 12,
        S_OWNY = 23'd1 << 13,
        S_OWNS = 23'd1 << 14,
        S_PA   = 23'd1 << 15,
        S_PX   = 23'd1 << 16,
        S_PY   = 23'd1 << 17,
        S_PS   = 23'd1 << 18,
        S_CM   = 23'd1 << 19,
        S_DEP  = 23'd1 << 20,
        S_NEXT = 23'd1 << 21,
        S_FIN  = 23'd1 << 22
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh000000007fffffff) begin
            sat32 = DEPTH_MAX;
        end else if (v < 64'shffffffff80000000) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = 32'(v);
        end
    endfunction

    function automatic logic [CW-1:0] absdiff(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
        logic signed [VW-1:0] d;
        d = VW'(a) - VW'(b);
        absdiff = d[VW-1] ? CW'(-d) : CW'(d);
    endfunction

    function automatic logic [QUOT_BITS-1:0] cap14(input logic [LW-1:0] q);
        cap14 = (q > LW'(Q14_ONE)) ? QUOT_BITS'(Q14_ONE) : q[QUOT_BITS-1:0];
    endfunction

    t_pt mem_a [MAX_VERTS];
    t_pt mem_b [MAX_VERTS];
    t_pt r_rd_a;
    t_pt r_rd_b;

    t_state                r_state;
    t_state                n_state;
    logic                  r_pass_b;
    logic [AW-1:0]         r_i;
    logic [AW-1:0]         r_k;
    logic [CNTW-1:0]       r_cnt_a;
    logic [CNTW-1:0]       r_cnt_b;
    logic                  r_ovf;
    t_pt                   r_ca;
    t_pt                   r_cb;
    logic [2:0]            r_cs;
    logic                  r_cj;
    logic                  r_best_v;
    logic                  r_ovalid;
    t_status               r_status;

    t_pt                   r_ei;
    t_pt                   r_ej;
    t_pt                   r_cand;
    t_pt                   r_bc;
    logic [CW-1:0]         r_ax;
    logic [CW-1:0]         r_ay;
    logic                  r_sx;
    logic                  r_sy;
    logic [LW-1:0]         r_len;
    logic [QUOT_BITS-1:0]  r_ux;
    logic signed [15:0]    r_nx;
    logic signed [15:0]    r_ny;
    logic signed [15:0]    r_bnx;
    logic signed [15:0]    r_bny;
    logic [PW-1:0]         r_acc;
    logic [PW-1:0]         r_la;
    logic signed [DW-1:0]  r_own;
    logic signed [DW-1:0]  r_omin;
    logic signed [DW-1:0]  r_best_d;
    t_out_word             r_out;

    logic                  in_acc;
    t_pt                   in_pt;
    logic                  full_a;
    logic                  full_b;
    logic                  empty_any;
    logic [CNTW-1:0]       en;
    logic [CNTW-1:0]       on;
    logic                  i_last;
    logic                  k_last;
    logic [AW-1:0]         j_w;
    logic [AW-1:0]         addr_e;
    logic [AW-1:0]         addr_a;
    logic [AW-1:0]         addr_b;
    t_pt                   rd_e;
    t_pt                   rd_o;
    t_pt                   c_sel;
    t_pt                   p_sel;
    logic signed [VW-1:0]  dx;
    logic signed [VW-1:0]  dy;
    logic [CW-1:0]         adx;
    logic [CW-1:0]         ady;
    logic                  halve;
    logic                  edge_zero;
    logic signed [VW-1:0]  mul_a;
    logic signed [VW-1:0]  mul_b;
    logic signed [PW-1:0]  mul_p;
    logic [PW-1:0]         sum_w;
    logic signed [DW-1:0]  dot;
    logic signed [DW-1:0]  dep;
    logic                  upd;
    logic                  out_load;
    t_unit_req             u_req;
    logic [UW-1:0]         u_num;
    logic                  u_done;
    logic [LW-1:0]         u_res;
    logic [QUOT_BITS-1:0]  uy;
    logic signed [DW-1:0]  dsh;

    assign in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_pt     = {i_in.data.coord_x[CW-1:0], i_in.data.coord_y[CW-1:0]};
    assign full_a    = (r_cnt_a == CNTW'(MAX_VERTS));
    assign full_b    = (r_cnt_b == CNTW'(MAX_VERTS));
    assign empty_any = (r_cnt_a == '0) || (r_cnt_b == '0);

    assign en     = r_pass_b ? r_cnt_b : r_cnt_a;
    assign on     = r_pass_b ? r_cnt_a : r_cnt_b;
    assign i_last = ((CNTW'(r_i) + CNTW'(1)) == en);
    assign k_last = ((CNTW'(r_k) + CNTW'(1)) == on);
    assign j_w    = i_last ? '0 : r_i + AW'(1);
    assign addr_e = (r_state == S_RJ) ? j_w : r_i;
    assign addr_a = r_pass_b ? r_k : addr_e;
    assign addr_b = r_pass_b ? addr_e : r_k;
    assign rd_e   = r_pass_b ? r_rd_b : r_rd_a;
    assign rd_o   = r_pass_b ? r_rd_a : r_rd_b;
    assign c_sel  = r_pass_b ? r_ca : r_cb;
    assign p_sel  = r_cj ? r_ej : r_ei;

    assign dx        = VW'(rd_e.x) - VW'(r_ei.x);
    assign dy        = VW'(rd_e.y) - VW'(r_ei.y);
    assign adx       = dx[VW-1] ? CW'(-dx) : CW'(dx);
    assign ady       = dy[VW-1] ? CW'(-dy) : CW'(dy);
    assign halve     = ((adx >> 31) != '0) || ((ady >> 31) != '0);
    assign edge_zero = (dx == '0) && (dy == '0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX: begin
                mul_a = $signed({1'b0, r_ax});
                mul_b = $signed({1'b0, r_ax});
            end
            S_SQY: begin
                mul_a = $signed({1'b0, r_ay});
                mul_b = $signed({1'b0, r_ay});
            end
            S_OWNX: begin
                mul_a = VW'(r_nx);
                mul_b = VW'(r_ei.x);
            end
            S_OWNY: begin
                mul_a = VW'(r_ny);
                mul_b = VW'(r_ei.y);
            end
            S_PX: begin
                mul_a = VW'(r_nx);
                mul_b = VW'(rd_o.x);
            end
            S_PY: begin
                mul_a = VW'(r_ny);
                mul_b = VW'(rd_o.y);
            end
            S_CM: begin
                unique case (r_cs)
                    3'd0: mul_a = $signed({1'b0, absdiff(p_sel.x, c_sel.x)});
                    3'd1: mul_a = $signed({1'b0, absdiff(p_sel.y, c_sel.y)});
                    3'd2: mul_a = $signed({1'b0, absdiff(r_cand.x, c_sel.x)});
                    3'd3: mul_a = $signed({1'b0, absdiff(r_cand.y, c_sel.y)});
                    default: mul_a = '0;
                endcase
                mul_b = mul_a;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ppsc_mul #(.VW(VW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign sum_w = r_acc + PW'(mul_p);
    assign dot   = $signed(sum_w[DW-1:0]);
    assign dep   = r_own - r_omin;
    assign upd   = !r_best_v || (dep < r_best_d);

    assign u_req = {((r_state == S_SQS) || (r_state == S_DXS) || (r_state == S_DYS)),
                    ((r_state == S_SQS) ? UOP_SQRT : UOP_DIV)};
    assign u_num       = (UW'((r_state == S_DXS) ? r_ax : r_ay) << Q14_BITS)
                         + UW'(r_len >> 1);

    ppsc_rootdiv #(.CW(CW)) u_rootdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .i_rad   (sum_w),
        .i_num   (u_num),
        .i_den   (r_len),
        .o_done  (u_done),
        .o_res   (u_res)
    );

    assign uy       = cap14(u_res);
    assign dsh      = r_best_d >>> Q14_BITS;
    assign out_load = (r_state == S_FIN) && (!r_ovalid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.data.cmd == CMD_COMPUTE)) begin
                    n_state = empty_any ? S_FIN : S_RI;
                end
            end
            S_RI:   n_state = S_RJ;
            S_RJ:   n_state = S_DL;
            S_DL:   n_state = edge_zero ? S_NEXT : S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_SQS;
            S_SQS:  n_state = S_RT;
            S_RT:   n_state = u_done ? S_DXS : S_RT;
            S_DXS:  n_state = S_DVX;
            S_DVX:  n_state = u_done ? S_DYS : S_DVX;
            S_DYS:  n_state = S_DVY;
            S_DVY:  n_state = u_done ? S_OWNX : S_DVY;
            S_OWNX: n_state = S_OWNY;
            S_OWNY: n_state = S_OWNS;
            S_OWNS: n_state = S_PA;
            S_PA:   n_state = S_PX;
            S_PX:   n_state = S_PY;
            S_PY:   n_state = S_PS;
            S_PS:   n_state = k_last ? S_CM : S_PA;
            S_CM:   n_state = ((r_cs == 3'd4) && r_cj) ? S_DEP : S_CM;
            S_DEP:  n_state = S_NEXT;
            S_NEXT: n_state = (i_last && r_pass_b) ? S_FIN : S_RI;
            S_FIN:  n_state = out_load ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pass_b <= 1'b0;
            r_i      <= '0;
            r_k      <= '0;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_ovf    <= 1'b0;
            r_ca     <= '0;
            r_cb     <= '0;
            r_cs     <= '0;
            r_cj     <= 1'b0;
            r_best_v <= 1'b0;
            r_ovalid <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in.data.cmd)
                            CMD_VERT_A: begin
                                if (full_a) r_ovf <= 1'b1;
                                else r_cnt_a <= r_cnt_a + CNTW'(1);
                            end
                            CMD_VERT_B: begin
                                if (full_b) r_ovf <= 1'b1;
                                else r_cnt_b <= r_cnt_b + CNTW'(1);
                            end
                            CMD_CENTRE_A: r_ca <= in_pt;
                            CMD_CENTRE_B: r_cb <= in_pt;
                            CMD_COMPUTE: begin
                                r_pass_b <= 1'b0;
                                r_i      <= '0;
                                r_best_v <= 1'b0;
                                r_status <= empty_any ? ST_EMPTY : (r_ovf ? ST_OVF : ST_OK);
                            end
                            default: ;
                        endcase
                    end
                end
                S_OWNS: r_k <= '0;
                S_PS: begin
                    if (k_last) begin
                        r_cs <= '0;
                        r_cj <= 1'b0;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                S_CM: begin
                    if (r_cs == 3'd4) begin
                        if (!r_cj) begin
                            r_cj <= 1'b1;
                            r_cs <= '0;
                        end
                    end else begin
                        r_cs <= r_cs + 3'd1;
                    end
                end
                S_DEP: begin
                    if (upd) r_best_v <= 1'b1;
                end
                S_NEXT: begin
                    if (i_last) begin
                        if (!r_pass_b) begin
                            r_pass_b <= 1'b1;
                            r_i      <= '0;
                        end
                    end else begin
                        r_i <= r_i + AW'(1);
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_cnt_a <= '0;
                        r_cnt_b <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // vertex stores
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_state == S_IDLE)) begin
            if ((i_in.data.cmd == CMD_VERT_A) && !full_a) begin
                mem_a[r_cnt_a[AW-1:0]] <= in_pt;
            end
            if ((i_in.data.cmd == CMD_VERT_B) && !full_b) begin
                mem_b[r_cnt_b[AW-1:0]] <= in_pt;
            end
        end
        r_rd_a <= mem_a[addr_a];
        r_rd_b <= mem_b[addr_b];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_RJ: r_ei <= rd_e;
            S_DL: begin
                r_ej <= rd_e;
                r_sx <= dx[VW-1];
                r_sy <= dy[VW-1];
                r_ax <= halve ? (adx >> 1) : adx;
                r_ay <= halve ? (ady >> 1) : ady;
            end
            S_SQY, S_OWNY, S_PY: r_acc <= PW'(mul_p);
            S_RT: begin
                if (u_done) r_len <= u_res;
            end
            S_DVX: begin
                if (u_done) r_ux <= uy;
            end
            S_DVY: begin
                if (u_done) begin
                    r_nx <= r_sy ? 16'(uy) : -16'(uy);
                    r_ny <= r_sx ? -16'(r_ux) : 16'(r_ux);
                end
            end
            S_OWNS: r_own <= dot;
            S_PS: begin
                if ((r_k == '0) || (dot < r_omin)) begin
                    r_omin <= dot;
                    r_cand <= rd_o;
                end
            end
            S_CM: begin
                if ((r_cs == 3'd1) || (r_cs == 3'd3)) begin
                    r_acc <= PW'(mul_p);
                end
                if (r_cs == 3'd2) begin
                    r_la <= sum_w;
                end
                if ((r_cs == 3'd4) && (r_la < sum_w)) begin
                    r_cand <= p_sel;
                end
            end
            S_DEP: begin
                if (upd) begin
                    r_best_d <= dep;
                    r_bnx    <= r_pass_b ? r_nx : -r_nx;
                    r_bny    <= r_pass_b ? r_ny : -r_ny;
                    r_bc     <= r_cand;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    r_out.status <= r_status;
                    if (r_best_v) begin
                        r_out.depth     <= sat32(64'(dsh));
                        r_out.normal_x  <= r_bnx;
                        r_out.normal_y  <= r_bny;
                        r_out.contact_x <= 32'(r_bc.x);
                        r_out.contact_y <= 32'(r_bc.y);
                        r_out.tangent_x <= sat32(64'(r_ca.y) - 64'(r_bc.y));
                        r_out.tangent_y <= sat32(64'(r_bc.x) - 64'(r_ca.x));
                    end else begin
                        r_out.depth     <= DEPTH_MAX;
                        r_out.normal_x  <= '0;
                        r_out.normal_y  <= '0;
                        r_out.contact_x <= '0;
                        r_out.contact_y <= '0;
                        r_out.tangent_x <= '0;
                        r_out.tangent_y <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNTW'(MAX_VERTS)) && (r_cnt_b <= CNTW'(MAX_VERTS)))
        else $error("vertex count beyond store depth");

    ap_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PS) |-> (CNTW'(r_k) < on))
        else $error("scan index beyond vertex count");

    ap_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.status == ST_EMPTY)) |->
        ((o_out.data.depth == DEPTH_MAX) && (o_out.data.normal_x == '0)
         && (o_out.data.normal_y == '0)))
        else $error("empty result word not cleared");

    ap_fin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> ((r_cnt_a == '0) && (r_cnt_b == '0) && !r_ovf && o_out.valid))
        else $error("stores not released after result");
`endif

endmodule

`default_nettype wire
